[design/tgr_pkg.sv]
// ----------------------------------------------------------------------------
// tgr_pkg
// Types and constants of the touch gesture recognizer.
// ----------------------------------------------------------------------------
package tgr_pkg;

	typedef enum logic [2:0] {
		EV_PRESS   = 3'd0,
		EV_RELEASE = 3'd1,
		EV_TAP     = 3'd2,
		EV_DRAG    = 3'd3,
		EV_REPEAT  = 3'd4
	} event_t;

	typedef enum logic [3:0] {
		PH_FIRST = 4'b0001,
		PH_DELAY = 4'b0010,
		PH_SLOW  = 4'b0100,
		PH_FAST  = 4'b1000
	} phase_t;

	typedef struct packed {
		event_t             kind;
		logic signed [12:0] pos_x;
		logic signed [12:0] pos_y;
		logic signed [13:0] delta_x;
		logic signed [13:0] delta_y;
		logic               last;
	} result_t;

	localparam logic [2:0] REG_ENABLE       = 3'd0;
	localparam logic [2:0] REG_ORIGIN_X     = 3'd1;
	localparam logic [2:0] REG_ORIGIN_Y     = 3'd2;
	localparam logic [2:0] REG_SENSE_LEFT   = 3'd3;
	localparam logic [2:0] REG_SENSE_TOP    = 3'd4;
	localparam logic [2:0] REG_SENSE_WIDTH  = 3'd5;
	localparam logic [2:0] REG_SENSE_HEIGHT = 3'd6;

	localparam logic [31:0] DEBOUNCE_MS     = 32'd50;
	localparam logic [31:0] TAP_MIN_MS      = 32'd10;
	localparam logic [31:0] TAP_MAX_MS      = 32'd2000;
	localparam logic [31:0] REPEAT_DELAY_MS = 32'd1000;
	localparam logic [31:0] REPEAT_SLOW_MS  = 32'd200;
	localparam logic [31:0] REPEAT_FAST_MS  = 32'd50;
	localparam logic [3:0]  REPEAT_SLOW_CNT = 4'd10;

endpackage

[design/touch_gesture_recognizer_top.sv]
// ----------------------------------------------------------------------------
// touch_gesture_recognizer_top
// Debounced touch button with press, release, tap, drag and auto-repeat.
//
// Input stream s_*: one touch sample per item. Output stream m_*: gesture
// events; m_tlast marks the last event a sample caused. A sample causes zero,
// one or two events. Config port cfg_*: register writes, always ready; write
// only while the block is idle, which the block itself does not enforce.
// An event leaves through the input register, then the result queue. One
// sample per cycle is taken while the four-entry result queue has room for
// two events; a sample causing two events puts two items into the queue.
// Reset clears config, input valid, the queue and the debounce/gesture state.
// When the receiver stalls the queue fills, the input register holds its
// sample and s_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
module touch_gesture_recognizer_top #(
	parameter int COORD_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// raw_pressed[0], touch_x[12:1], touch_y[24:13], now_ms[56:25], zero pad
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// pos_x[12:0], pos_y[25:13], delta_x[39:26], delta_y[53:40], zero pad
	output logic [55:0] m_tdata,
	// event_kind[2:0]
	output logic [2:0]  m_tuser,
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	localparam logic [11:0] COORD_MASK = 12'((33'd1 << COORD_BITS) - 33'd1);

	// configuration
	logic        enable_q;
	logic [11:0] origin_x_q, origin_y_q, sense_w_q, sense_h_q;
	logic signed [11:0] sense_l_q, sense_t_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			origin_x_q <= '0;
			origin_y_q <= '0;
			sense_l_q  <= '0;
			sense_t_q  <= '0;
			sense_w_q  <= '0;
			sense_h_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				tgr_pkg::REG_ENABLE:       enable_q   <= cfg_data[0];
				tgr_pkg::REG_ORIGIN_X:     origin_x_q <= cfg_data;
				tgr_pkg::REG_ORIGIN_Y:     origin_y_q <= cfg_data;
				tgr_pkg::REG_SENSE_LEFT:   sense_l_q  <= cfg_data;
				tgr_pkg::REG_SENSE_TOP:    sense_t_q  <= cfg_data;
				tgr_pkg::REG_SENSE_WIDTH:  sense_w_q  <= cfg_data;
				tgr_pkg::REG_SENSE_HEIGHT: sense_h_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	logic        valid_s1;
	logic        raw_s1;
	logic [11:0] tx_s1, ty_s1;
	logic [31:0] now_s1;
	logic [2:0]  count_q;
	logic        proc;

	assign proc     = valid_s1 && (count_q <= 3'd2);
	assign s_tready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			raw_s1 <= s_tdata[0];
			tx_s1  <= s_tdata[12:1];
			ty_s1  <= s_tdata[24:13];
			now_s1 <= s_tdata[56:25];
		end
	end

	// gesture state
	logic        deb_level_q, deb_run_q, active_q;
	logic [31:0] deb_start_q, press_time_q, rep_time_q;
	logic [11:0] held_x_q, held_y_q;
	logic signed [12:0] start_x_q, start_y_q, end_x_q, end_y_q;
	tgr_pkg::phase_t phase_q;
	logic [3:0]  rep_cnt_q;

	// next-state logic
	logic        run_n, pressed, in_rect;
	logic [31:0] start_n;
	logic [11:0] held_x_n, held_y_n;
	logic signed [14:0] lo_x, lo_y, hi_x, hi_y, hx, hy;
	logic signed [12:0] rel_x, rel_y, pos_x, pos_y, ref_x, ref_y;
	logic signed [13:0] dgen_x, dgen_y;
	logic        press, rel_in, rel_out, drag_stg, drag_ev, tap, fire;
	logic [31:0] held_ms, rtime_cur, elapsed;
	tgr_pkg::phase_t phase_cur, phase_n;
	logic [3:0]  cnt_n, cnt_inc;
	logic        va, vb;
	tgr_pkg::result_t res_a, res_b;

	always_comb begin
		run_n   = (raw_s1 != deb_level_q) ? raw_s1 : deb_run_q;
		start_n = (raw_s1 && !deb_level_q) ? now_s1 : deb_start_q;
		pressed = run_n && ((now_s1 - start_n) > tgr_pkg::DEBOUNCE_MS);
		held_x_n = pressed ? (tx_s1 & COORD_MASK) : held_x_q;
		held_y_n = pressed ? (ty_s1 & COORD_MASK) : held_y_q;

		lo_x = $signed({3'b000, origin_x_q}) + 15'(sense_l_q);
		lo_y = $signed({3'b000, origin_y_q}) + 15'(sense_t_q);
		hi_x = lo_x + $signed({3'b000, sense_w_q});
		hi_y = lo_y + $signed({3'b000, sense_h_q});
		hx   = $signed({3'b000, held_x_n});
		hy   = $signed({3'b000, held_y_n});
		in_rect = (hx >= lo_x) && (hx < hi_x) && (hy >= lo_y) && (hy < hi_y);

		rel_x = $signed({1'b0, held_x_n}) - $signed({1'b0, origin_x_q});
		rel_y = $signed({1'b0, held_y_n}) - $signed({1'b0, origin_y_q});

		press    = pressed && in_rect && !active_q;
		rel_in   = !pressed && active_q;
		rel_out  = pressed && !in_rect && active_q;
		drag_stg = pressed && in_rect;

		ref_x   = press ? rel_x : start_x_q;
		ref_y   = press ? rel_y : start_y_q;
		drag_ev = drag_stg && ((ref_x != rel_x) || (ref_y != rel_y));
		pos_x   = rel_out ? end_x_q : rel_x;
		pos_y   = rel_out ? end_y_q : rel_y;
		dgen_x  = 14'(pos_x) - 14'(ref_x);
		dgen_y  = 14'(pos_y) - 14'(ref_y);

		held_ms = now_s1 - press_time_q;
		tap = (held_ms > tgr_pkg::TAP_MIN_MS) && (held_ms < tgr_pkg::TAP_MAX_MS);

		phase_cur = press ? tgr_pkg::PH_FIRST : phase_q;
		rtime_cur = press ? now_s1 : rep_time_q;
		elapsed   = now_s1 - rtime_cur;
		cnt_inc   = rep_cnt_q + 4'd1;
		fire      = 1'b0;
		phase_n   = phase_cur;
		cnt_n     = rep_cnt_q;
		case (phase_cur)
			tgr_pkg::PH_FIRST: begin
				phase_n = tgr_pkg::PH_DELAY;
				fire    = 1'b1;
			end
			tgr_pkg::PH_DELAY: begin
				if (elapsed >= tgr_pkg::REPEAT_DELAY_MS) begin
					phase_n = tgr_pkg::PH_SLOW;
					cnt_n   = '0;
					fire    = 1'b1;
				end
			end
			tgr_pkg::PH_SLOW: begin
				if (elapsed >= tgr_pkg::REPEAT_SLOW_MS) begin
					fire  = 1'b1;
					cnt_n = cnt_inc;
					if (cnt_inc == tgr_pkg::REPEAT_SLOW_CNT) begin
						phase_n = tgr_pkg::PH_FAST;
					end
				end
			end
			default: begin
				if (elapsed >= tgr_pkg::REPEAT_FAST_MS) begin
					fire = 1'b1;
				end
			end
		endcase

		va = press || rel_in || rel_out || drag_ev;
		vb = (rel_in && tap) || (drag_stg && fire);

		res_a.kind    = press ? tgr_pkg::EV_PRESS :
		                (rel_in || rel_out) ? tgr_pkg::EV_RELEASE : tgr_pkg::EV_DRAG;
		res_a.pos_x   = pos_x;
		res_a.pos_y   = pos_y;
		res_a.delta_x = press ? 14'(rel_x) : dgen_x;
		res_a.delta_y = press ? 14'(rel_y) : dgen_y;
		res_a.last    = !vb;

		res_b.kind    = rel_in ? tgr_pkg::EV_TAP : tgr_pkg::EV_REPEAT;
		res_b.pos_x   = pos_x;
		res_b.pos_y   = pos_y;
		res_b.delta_x = dgen_x;
		res_b.delta_y = dgen_y;
		res_b.last    = 1'b1;
	end

	logic step;
	assign step = proc && enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_level_q  <= 1'b0;
			deb_run_q    <= 1'b0;
			deb_start_q  <= '0;
			held_x_q     <= '0;
			held_y_q     <= '0;
			active_q     <= 1'b0;
			press_time_q <= '0;
			start_x_q    <= '0;
			start_y_q    <= '0;
			end_x_q      <= '0;
			end_y_q      <= '0;
			rep_time_q   <= '0;
			phase_q      <= tgr_pkg::PH_FIRST;
			rep_cnt_q    <= '0;
		end else if (step) begin
			deb_level_q <= raw_s1;
			deb_run_q   <= run_n;
			deb_start_q <= start_n;
			held_x_q    <= held_x_n;
			held_y_q    <= held_y_n;
			if (press) begin
				active_q     <= 1'b1;
				press_time_q <= now_s1;
			end else if (rel_in || rel_out) begin
				active_q <= 1'b0;
			end
			if (drag_stg) begin
				start_x_q <= rel_x;
				start_y_q <= rel_y;
				phase_q   <= phase_n;
				rep_cnt_q <= cnt_n;
				rep_time_q <= fire ? now_s1 : rtime_cur;
			end
			if (drag_stg || rel_in) begin
				end_x_q <= rel_x;
				end_y_q <= rel_y;
			end
		end
	end

	// result queue
	tgr_pkg::result_t fifo_q [4];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic       push_a, push_b, pop;
	logic [1:0] n_push;

	assign push_a = step && va;
	assign push_b = step && vb;
	assign n_push = {1'b0, push_a} + {1'b0, push_b};
	assign pop    = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			count_q  <= count_q + {1'b0, n_push} - {2'b00, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push_a) begin
			fifo_q[wr_ptr_q] <= res_a;
		end
		if (push_b) begin
			fifo_q[push_a ? (wr_ptr_q + 2'd1) : wr_ptr_q] <= res_b;
		end
	end

	tgr_pkg::result_t head;
	assign head     = fifo_q[rd_ptr_q];
	assign m_tvalid = (count_q != 3'd0);
	assign m_tuser  = head.kind;
	assign m_tlast  = head.last;
	assign m_tdata  = {2'b00, head.delta_y, head.delta_x, head.pos_y, head.pos_x};

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("result queue overflow");

	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push_a || push_b) |-> (count_q <= 3'd2))
		else $error("push without room");

	a_press: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(active_q) |-> $past(push_a && res_a.kind == tgr_pkg::EV_PRESS))
		else $error("activation without press event");

	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(active_q) |-> $past(push_a && res_a.kind == tgr_pkg::EV_RELEASE))
		else $error("deactivation without release event");

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for touch_gesture_recognizer_top. Touch samples are
// streamed in as press/drag/release gestures with random timing, and a
// behavioral predictor of debounce, hit test, tap and auto-repeat builds the
// expected event list that every output item is compared against.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [11:0] cfg_data;

	always #5 clk = ~clk;

	touch_gesture_recognizer_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// register shadow
	logic        cfg_en;
	logic [11:0] cfg_org_x, cfg_org_y, cfg_left, cfg_top, cfg_wid, cfg_hgt;

	// gesture state
	logic        deb_level, deb_run, touch_active;
	logic [31:0] deb_start, press_ms, rep_ms;
	logic [11:0] held_x, held_y;
	int          ref_x, ref_y, end_x, end_y;
	tgr_pkg::phase_t rep_phase;
	logic [3:0]  rep_count;

	tgr_pkg::result_t pending_events[$];
	tgr_pkg::result_t got_event, want_event;
	int          error_count = 0;
	int          samples_sent = 0;
	int          burst_left = 0;
	int          gap_max = 0;
	int          rx_left = 0;
	int          rx_mode = 0;
	logic [31:0] sample_ms;

	function automatic tgr_pkg::result_t make_event(tgr_pkg::event_t k, int px, int py,
			int dx, int dy);
		tgr_pkg::result_t r;
		r.kind    = k;
		r.pos_x   = px[12:0];
		r.pos_y   = py[12:0];
		r.delta_x = dx[13:0];
		r.delta_y = dy[13:0];
		r.last    = 1'b0;
		return r;
	endfunction

	function automatic tgr_pkg::result_t end_event(tgr_pkg::event_t k);
		return make_event(k, end_x, end_y, end_x - ref_x, end_y - ref_y);
	endfunction

	function automatic void predict_gesture(logic raw, logic [11:0] x, logic [11:0] y,
			logic [31:0] t);
		tgr_pkg::result_t evs[$];
		logic        touching, hit, fire;
		int          ox, oy, lx, ty, hx, hy;
		logic [31:0] held;
		if (!cfg_en)
			return;
		if (raw != deb_level) begin
			deb_level = raw;
			deb_run   = raw;
			if (raw)
				deb_start = t;
		end
		touching = deb_run && ((t - deb_start) > tgr_pkg::DEBOUNCE_MS);
		if (touching) begin
			held_x = x;
			held_y = y;
		end
		ox  = int'(cfg_org_x);
		oy  = int'(cfg_org_y);
		lx  = ox + int'($signed(cfg_left));
		ty  = oy + int'($signed(cfg_top));
		hx  = int'(held_x);
		hy  = int'(held_y);
		hit = hx >= lx && hx < lx + int'(cfg_wid) && hy >= ty && hy < ty + int'(cfg_hgt);

		if (touching && hit && !touch_active) begin
			touch_active = 1'b1;
			press_ms     = t;
			ref_x        = hx - ox;
			ref_y        = hy - oy;
			rep_ms       = t;
			rep_phase    = tgr_pkg::PH_FIRST;
			evs.push_back(make_event(tgr_pkg::EV_PRESS, ref_x, ref_y, ref_x, ref_y));
		end
		if (!touching && touch_active) begin
			held         = t - press_ms;
			touch_active = 1'b0;
			end_x        = hx - ox;
			end_y        = hy - oy;
			evs.push_back(end_event(tgr_pkg::EV_RELEASE));
			if (held > tgr_pkg::TAP_MIN_MS && held < tgr_pkg::TAP_MAX_MS)
				evs.push_back(end_event(tgr_pkg::EV_TAP));
		end
		if (touching && !hit && touch_active) begin
			touch_active = 1'b0;
			evs.push_back(end_event(tgr_pkg::EV_RELEASE));
		end
		if (touching && hit && touch_active) begin
			fire  = 1'b0;
			end_x = hx - ox;
			end_y = hy - oy;
			if (ref_x != end_x || ref_y != end_y)
				evs.push_back(end_event(tgr_pkg::EV_DRAG));
			case (rep_phase)
				tgr_pkg::PH_FIRST: begin
					rep_phase = tgr_pkg::PH_DELAY;
					fire      = 1'b1;
				end
				tgr_pkg::PH_DELAY: begin
					if ((t - rep_ms) >= tgr_pkg::REPEAT_DELAY_MS) begin
						rep_phase = tgr_pkg::PH_SLOW;
						rep_count = '0;
						fire      = 1'b1;
					end
				end
				tgr_pkg::PH_SLOW: begin
					if ((t - rep_ms) >= tgr_pkg::REPEAT_SLOW_MS) begin
						fire      = 1'b1;
						rep_count = rep_count + 4'd1;
						if (rep_count == tgr_pkg::REPEAT_SLOW_CNT)
							rep_phase = tgr_pkg::PH_FAST;
					end
				end
				default: begin
					if ((t - rep_ms) >= tgr_pkg::REPEAT_FAST_MS)
						fire = 1'b1;
				end
			endcase
			if (fire) begin
				rep_ms = t;
				evs.push_back(end_event(tgr_pkg::EV_REPEAT));
			end
			ref_x = end_x;
			ref_y = end_y;
		end
		if (evs.size() > 0)
			evs[evs.size() - 1].last = 1'b1;
		foreach (evs[i])
			pending_events.push_back(evs[i]);
	endfunction

	task automatic send_sample(logic raw, logic [11:0] x, logic [11:0] y, logic [31:0] t);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if (gap_max != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, t, y, x, raw};
		do @(posedge clk); while (!s_tready);
		samples_sent++;
		predict_gesture(raw, x, y, t);
	endtask

	// stop sending and wait for the block to drain
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic load_config(logic en, logic [11:0] ox, logic [11:0] oy, logic [11:0] sl,
			logic [11:0] st, logic [11:0] w, logic [11:0] h);
		logic [11:0] vals[7];
		logic [2:0]  idx[7];
		vals = '{{11'd0, en}, ox, oy, sl, st, w, h};
		idx  = '{tgr_pkg::REG_ENABLE, tgr_pkg::REG_ORIGIN_X, tgr_pkg::REG_ORIGIN_Y,
			tgr_pkg::REG_SENSE_LEFT, tgr_pkg::REG_SENSE_TOP, tgr_pkg::REG_SENSE_WIDTH,
			tgr_pkg::REG_SENSE_HEIGHT};
		for (int i = 0; i < 7; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			case (idx[i])
				tgr_pkg::REG_ENABLE:       cfg_en    = vals[i][0];
				tgr_pkg::REG_ORIGIN_X:     cfg_org_x = vals[i];
				tgr_pkg::REG_ORIGIN_Y:     cfg_org_y = vals[i];
				tgr_pkg::REG_SENSE_LEFT:   cfg_left  = vals[i];
				tgr_pkg::REG_SENSE_TOP:    cfg_top   = vals[i];
				tgr_pkg::REG_SENSE_WIDTH:  cfg_wid   = vals[i];
				default:                   cfg_hgt   = vals[i];
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [11:0] clamp_coord(int v);
		if (v < 0)
			return 12'd0;
		if (v > 4095)
			return 12'd4095;
		return v[11:0];
	endfunction

	// random point inside [lo, lo+span) on the panel, anywhere if that is empty
	function automatic logic [11:0] pick_coord(int lo, logic [11:0] span);
		int a, b;
		a = (lo < 0) ? 0 : lo;
		b = lo + int'(span) - 1;
		if (b > 4095)
			b = 4095;
		if (span == 0 || a > b)
			return 12'($urandom_range(0, 4095));
		return 12'($urandom_range(b, a));
	endfunction

	task automatic random_gestures(int count);
		int          stop_at, len, dt_max, k, lo_x, lo_y;
		logic [11:0] px, py;
		stop_at = samples_sent + count;
		lo_x    = int'(cfg_org_x) + int'($signed(cfg_left));
		lo_y    = int'(cfg_org_y) + int'($signed(cfg_top));
		while (samples_sent < stop_at) begin
			k = $urandom_range(0, 9);
			if (k < 8) begin
				len    = (k == 0) ? $urandom_range(20, 45) : $urandom_range(1, 10);
				dt_max = (k == 0) ? 260 : 120;
				px     = pick_coord(lo_x, cfg_wid);
				py     = pick_coord(lo_y, cfg_hgt);
				for (int i = 0; i < len; i++) begin
					case ($urandom_range(0, 19))
						0: begin
							px = 12'($urandom);
							py = 12'($urandom);
						end
						1, 2, 3: begin
							px = pick_coord(lo_x, cfg_wid);
							py = pick_coord(lo_y, cfg_hgt);
						end
						4, 5, 6, 7, 8, 9, 10, 11: begin
							px = clamp_coord(int'(px) + int'($urandom_range(0, 6)) - 3);
							py = clamp_coord(int'(py) + int'($urandom_range(0, 6)) - 3);
						end
						default: ;
					endcase
					send_sample(1'b1, px, py, sample_ms);
					sample_ms += $urandom_range(1, dt_max);
				end
				if ($urandom_range(0, 7) == 0)
					sample_ms += $urandom_range(1500, 2600);
				send_sample(1'b0, 12'($urandom), 12'($urandom), sample_ms);
				sample_ms += $urandom_range(1, 200);
			end else begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					send_sample(1'($urandom_range(0, 1)), 12'($urandom), 12'($urandom),
						sample_ms);
					sample_ms += $urandom_range(0, 70);
				end
			end
			if ($urandom_range(0, 15) == 0)
				sample_ms += $urandom;
		end
	endtask

	task automatic test_disabled_after_reset();
		gap_max = 0;
		sample_ms = $urandom;
		send_sample(1'b1, 12'd100, 12'd100, sample_ms);
		send_sample(1'b1, 12'd100, 12'd100, sample_ms + 32'd100);
		send_sample(1'b0, 12'd0, 12'd0, sample_ms + 32'd200);
		settle();
	endtask

	// window x 900..1199, y 2050..2249, origin (1000, 2000)
	task automatic test_directed_gestures();
		logic [31:0] t0, t1;
		gap_max = 3;
		load_config(1'b1, 12'd1000, 12'd2000, 12'hF9C, 12'd50, 12'd300, 12'd200);
		t0 = 32'hFFFF_FF00;
		send_sample(1'b1, 12'd950, 12'd2100, t0);
		send_sample(1'b1, 12'd960, 12'd2100, t0 + 32'd50);
		send_sample(1'b1, 12'd970, 12'd2110, t0 + 32'd51);
		send_sample(1'b1, 12'd970, 12'd2110, t0 + 32'd300);
		send_sample(1'b1, 12'd1000, 12'd2120, t0 + 32'd1100);
		send_sample(1'b1, 12'd1010, 12'd2120, t0 + 32'd1299);
		send_sample(1'b1, 12'd1010, 12'd2120, t0 + 32'd1300);
		send_sample(1'b1, 12'd1200, 12'd2120, t0 + 32'd1400);
		send_sample(1'b0, 12'd0, 12'd0, t0 + 32'd1500);
		// tap just above the minimum hold
		t1 = t0 + 32'd2000;
		send_sample(1'b1, 12'd900, 12'd2050, t1);
		send_sample(1'b1, 12'd900, 12'd2050, t1 + 32'd51);
		send_sample(1'b0, 12'd4095, 12'd4095, t1 + 32'd62);
		// hold of exactly the minimum: no tap
		send_sample(1'b1, 12'd1199, 12'd2249, t1 + 32'd100);
		send_sample(1'b1, 12'd1199, 12'd2249, t1 + 32'd151);
		send_sample(1'b0, 12'd1199, 12'd2249, t1 + 32'd161);
		// bounce restarts the debounce; hold of exactly the maximum: no tap
		send_sample(1'b1, 12'd1100, 12'd2200, t1 + 32'd200);
		send_sample(1'b0, 12'd1100, 12'd2200, t1 + 32'd220);
		send_sample(1'b1, 12'd1100, 12'd2200, t1 + 32'd240);
		send_sample(1'b1, 12'd1100, 12'd2200, t1 + 32'd290);
		send_sample(1'b1, 12'd1100, 12'd2200, t1 + 32'd291);
		send_sample(1'b0, 12'd1100, 12'd2200, t1 + 32'd2291);
		settle();
	endtask

	task automatic test_random_window();
		gap_max = 4;
		sample_ms = $urandom;
		random_gestures(200);
		gap_max = 0;
		random_gestures(80);
		settle();
	endtask

	task automatic test_random_extremes();
		gap_max = 5;
		load_config(1'b1, 12'd4095, 12'd4095, 12'h800, 12'h800, 12'd4095, 12'd4095);
		random_gestures(120);
		settle();
		load_config(1'b1, 12'd0, 12'd0, 12'h7FF, 12'h7FF, 12'd4095, 12'd4095);
		random_gestures(80);
		settle();
		gap_max = 2;
		load_config(1'b1, 12'd0, 12'd0, 12'd0, 12'd0, 12'd4095, 12'd4095);
		random_gestures(100);
		settle();
	endtask

	task automatic test_zero_size_window();
		gap_max = 3;
		load_config(1'b1, 12'd2048, 12'd2048, 12'd0, 12'd0, 12'd0, 12'd4095);
		random_gestures(30);
		settle();
		load_config(1'b1, 12'd2048, 12'd2048, 12'd0, 12'd0, 12'd4095, 12'd0);
		random_gestures(30);
		settle();
	endtask

	// disable in the middle of a press, then resume
	task automatic test_disable_midway();
		gap_max = 4;
		load_config(1'b1, 12'd500, 12'd500, 12'hF38, 12'hF38, 12'd1000, 12'd1000);
		send_sample(1'b1, 12'd600, 12'd600, sample_ms);
		send_sample(1'b1, 12'd600, 12'd600, sample_ms + 32'd60);
		send_sample(1'b1, 12'd610, 12'd605, sample_ms + 32'd120);
		sample_ms += 32'd200;
		settle();
		load_config(1'b0, 12'd500, 12'd500, 12'hF38, 12'hF38, 12'd1000, 12'd1000);
		random_gestures(20);
		settle();
		load_config(1'b1, 12'd500, 12'd500, 12'hF38, 12'hF38, 12'd1000, 12'd1000);
		random_gestures(60);
		settle();
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(16, 200);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			0:       m_tready <= 1'b1;
			1:       m_tready <= ($urandom_range(0, 3) != 0);
			2:       m_tready <= ($urandom_range(0, 7) == 0);
			default: m_tready <= 1'($urandom_range(0, 1));
		endcase
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			got_event.kind    = tgr_pkg::event_t'(m_tuser);
			got_event.pos_x   = m_tdata[12:0];
			got_event.pos_y   = m_tdata[25:13];
			got_event.delta_x = m_tdata[39:26];
			got_event.delta_y = m_tdata[53:40];
			got_event.last    = m_tlast;
			if (pending_events.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("%0t: unexpected item kind %0d pos (%0d,%0d)",
						$realtime, got_event.kind, got_event.pos_x, got_event.pos_y,
						" delta (%0d,%0d) last %0b",
						got_event.delta_x, got_event.delta_y, got_event.last);
			end else begin
				want_event = pending_events.pop_front();
				if (got_event.kind !== want_event.kind || got_event.pos_x !== want_event.pos_x ||
						got_event.pos_y !== want_event.pos_y ||
						got_event.delta_x !== want_event.delta_x ||
						got_event.delta_y !== want_event.delta_y ||
						got_event.last !== want_event.last) begin
					error_count++;
					if (error_count <= 10)
						$display("%0t: mismatch exp kind %0d pos (%0d,%0d)",
							$realtime, want_event.kind, want_event.pos_x,
							want_event.pos_y,
							" delta (%0d,%0d) last %0b,",
							want_event.delta_x, want_event.delta_y, want_event.last,
							" got kind %0d pos (%0d,%0d)",
							got_event.kind, got_event.pos_x, got_event.pos_y,
							" delta (%0d,%0d) last %0b",
							got_event.delta_x, got_event.delta_y, got_event.last);
				end
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		m_tready     = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = tgr_pkg::REG_ENABLE;
		cfg_data     = '0;
		cfg_en       = 1'b0;
		cfg_org_x    = '0;
		cfg_org_y    = '0;
		cfg_left     = '0;
		cfg_top      = '0;
		cfg_wid      = '0;
		cfg_hgt      = '0;
		deb_level    = 1'b0;
		deb_run      = 1'b0;
		touch_active = 1'b0;
		deb_start    = '0;
		press_ms     = '0;
		rep_ms       = '0;
		held_x       = '0;
		held_y       = '0;
		ref_x        = 0;
		ref_y        = 0;
		end_x        = 0;
		end_y        = 0;
		rep_phase    = tgr_pkg::PH_FIRST;
		rep_count    = '0;
		sample_ms    = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_disabled_after_reset();
		test_directed_gestures();
		test_random_window();
		test_random_extremes();
		test_zero_size_window();
		test_disable_midway();
		settle();
		repeat (20) @(posedge clk);
		if (error_count == 0 && pending_events.size() == 0) begin
			$display("PASS touch_gesture_recognizer_top");
		end else begin
			$display("FAIL touch_gesture_recognizer_top");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL touch_gesture_recognizer_top");
		$finish;
	end

endmodule

[filelist.f]
design/tgr_pkg.sv
design/touch_gesture_recognizer_top.sv
dv/testbench.sv
